[rtl/pcr_pkg.sv]
`timescale 1ns / 1ps
package pcr_pkg;

	// Field and register widths.
	localparam int PIX_W = 12;
	localparam int JITTER_BITS = 8;
	localparam int UX_W = PIX_W + JITTER_BITS;
	localparam int RES_W = 13;
	localparam int MAX_RESOLUTION = 4096;
	localparam int LANE_W = 16;
	localparam int CFG_W = 48;
	localparam int CFG_IDX_W = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_CAM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_XSPAN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YSPAN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

	// Register values after reset.
	localparam logic [CFG_W-1:0] RESET_CAM = 48'h0000_0600_0000;
	localparam logic [CFG_W-1:0] RESET_CORNER = 48'h0100_0400_0100;
	localparam logic [CFG_W-1:0] RESET_XSPAN = 48'h0000_0000_FE00;
	localparam logic [CFG_W-1:0] RESET_YSPAN = 48'hFE00_0000_0000;
	localparam logic [RES_W-1:0] RESET_RES = 13'd256;

	// Datapath widths of the projection and normalization pipelines.
	localparam int NUMA_W = UX_W + 16 - JITTER_BITS;
	localparam int DIVA_STEPS = NUMA_W;
	localparam int DIVC_STEPS = LANE_W - 1;
	localparam int MR_W = LANE_W + RES_W - 1;
	localparam int P_W = LANE_W + NUMA_W + 1;
	localparam int D_W = P_W + 2;
	localparam int M_W = D_W - 1;
	localparam int A_W = 30;
	localparam int SQ_W = 2 * A_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int SQRT_STEPS = A_W + 1;
	localparam int ROOT_W = SQRT_STEPS;
	localparam int SREM_W = ROOT_W + 2;
	localparam int DIVN_STEPS = 15;
	localparam int QN_W = ROOT_W + 1;
	localparam int NN_W = A_W + DIVN_STEPS + 1;

	// Pipeline latencies in cycles; RESULT_LATENCY runs from accept to result strobe.
	localparam int PROJ_LAT = DIVA_STEPS + DIVC_STEPS + 5;
	localparam int NORM_LAT = SQRT_STEPS + DIVN_STEPS + 8;
	localparam int RESULT_LATENCY = 1 + PROJ_LAT + NORM_LAT;

	typedef struct packed {
		logic [2:0][LANE_W-1:0] cam;
		logic [2:0][LANE_W-1:0] corner;
		logic [2:0][LANE_W-1:0] span_x;
		logic [2:0][LANE_W-1:0] span_y;
		logic [RES_W-1:0] res_x;
		logic [RES_W-1:0] res_y;
	} pcr_cfg_t;

	typedef struct packed {
		logic [UX_W-1:0] ux;
		logic [UX_W-1:0] uy;
	} pcr_item_t;

endpackage

[rtl/pcr_front.sv]
`timescale 1ns / 1ps
module pcr_front import pcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [PIX_W-1:0] pixel_x,
	input logic [PIX_W-1:0] pixel_y,
	input logic [JITTER_BITS-1:0] jitter_x,
	input logic [JITTER_BITS-1:0] jitter_y,
	input logic cfg_valid,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	output logic cfg_ready,
	output logic push,
	output pcr_item_t push_item,
	output pcr_cfg_t cfg
);

	pcr_cfg_t cfg_q;

	// A resolution of zero acts as one, and large ones saturate.
	function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W+3:0] v);
		if (v == '0) begin
			return RES_W'(1);
		end else if (v > (RES_W+4)'(MAX_RESOLUTION)) begin
			return RES_W'(MAX_RESOLUTION);
		end
		return v[RES_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam <= RESET_CAM;
			cfg_q.corner <= RESET_CORNER;
			cfg_q.span_x <= RESET_XSPAN;
			cfg_q.span_y <= RESET_YSPAN;
			cfg_q.res_x <= RESET_RES;
			cfg_q.res_y <= RESET_RES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CAM: cfg_q.cam <= cfg_data;
				REG_CORNER: cfg_q.corner <= cfg_data;
				REG_XSPAN: cfg_q.span_x <= cfg_data;
				REG_YSPAN: cfg_q.span_y <= cfg_data;
				REG_WIDTH: cfg_q.res_x <= clamp_res(cfg_data[RES_W+3:0]);
				REG_HEIGHT: cfg_q.res_y <= clamp_res(cfg_data[RES_W+3:0]);
				default: ;
			endcase
		end
	end

	// Each accepted word becomes a fixed point frame coordinate pair.
	assign push = start && !busy;
	assign push_item.ux = {pixel_x, jitter_x};
	assign push_item.uy = {pixel_y, jitter_y};

endmodule

[rtl/pcr_queue.sv]
`timescale 1ns / 1ps
module pcr_queue import pcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input pcr_item_t push_item,
	output logic full,
	output logic pop_valid,
	output pcr_item_t pop_item
);

	pcr_item_t mem [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;

	// The back end takes a word in every cycle that one is waiting.
	assign pop_valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign pop_item = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop_valid) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop_valid);
		end
	end

endmodule

[rtl/pcr_proj.sv]
`timescale 1ns / 1ps
module pcr_proj import pcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input pcr_item_t in_item,
	input pcr_cfg_t cfg,
	output logic out_valid,
	output logic [2:0][D_W-1:0] out_d
);

	logic [RES_W-1:0] den [2];
	logic [2:0][LANE_W-1:0] span [2];
	logic [LANE_W-1:0] smag [2][3];

	logic [DIVA_STEPS:0] a_vld_s1;
	logic [RES_W-1:0] a_rem_s1 [DIVA_STEPS+1][2];
	logic [NUMA_W-1:0] a_nq_s1 [DIVA_STEPS+1][2];

	logic vld_s2;
	logic signed [P_W-1:0] p_s2 [2][3];
	logic [MR_W-1:0] mr_s2 [2][3];
	logic neg_s2 [2][3];

	logic [DIVC_STEPS:0] c_vld_s3;
	logic [RES_W-1:0] c_rem_s3 [DIVC_STEPS+1][2][3];
	logic [DIVC_STEPS-1:0] c_nq_s3 [DIVC_STEPS+1][2][3];
	logic signed [P_W-1:0] p_s3 [DIVC_STEPS+1][2][3];
	logic neg_s3 [DIVC_STEPS+1][2][3];

	logic vld_s4;
	logic signed [P_W:0] t_next [2][3];
	logic signed [P_W:0] t_s4 [2][3];

	logic vld_s5;
	logic signed [D_W-1:0] d_next [3];
	logic signed [D_W-1:0] d_s5 [3];

	// One step of restoring division by a resolution.
	function automatic logic div_ge(input logic [RES_W-1:0] rem, input logic b,
			input logic [RES_W-1:0] d);
		logic [RES_W-1:0] t;
		t = {rem[RES_W-2:0], b};
		return t >= d;
	endfunction

	function automatic logic [RES_W-1:0] div_rem(input logic [RES_W-1:0] rem, input logic b,
			input logic [RES_W-1:0] d);
		logic [RES_W-1:0] t;
		t = {rem[RES_W-2:0], b};
		return (t >= d) ? t - d : t;
	endfunction

	assign den[0] = cfg.res_x;
	assign den[1] = cfg.res_y;
	assign span[0] = cfg.span_x;
	assign span[1] = cfg.span_y;

	always_comb begin
		for (int x = 0; x < 2; x++) begin
			for (int k = 0; k < 3; k++) begin
				smag[x][k] = span[x][k][LANE_W-1] ? LANE_W'(-span[x][k]) : span[x][k];
			end
		end
	end

	// Valid bits of the whole pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s1 <= '0;
			vld_s2 <= 1'b0;
			c_vld_s3 <= '0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			a_vld_s1 <= {a_vld_s1[DIVA_STEPS-1:0], in_valid};
			vld_s2 <= a_vld_s1[DIVA_STEPS];
			c_vld_s3 <= {c_vld_s3[DIVC_STEPS-1:0], vld_s2};
			vld_s4 <= c_vld_s3[DIVC_STEPS];
			vld_s5 <= vld_s4;
		end
	end

	// Coordinate divided by resolution: one quotient bit per stage.
	always_ff @(posedge clk) begin
		a_rem_s1[0][0] <= '0;
		a_rem_s1[0][1] <= '0;
		a_nq_s1[0][0] <= NUMA_W'(in_item.ux) << (16 - JITTER_BITS);
		a_nq_s1[0][1] <= NUMA_W'(in_item.uy) << (16 - JITTER_BITS);
		for (int i = 0; i < DIVA_STEPS; i++) begin
			for (int x = 0; x < 2; x++) begin
				a_rem_s1[i+1][x] <= div_rem(a_rem_s1[i][x], a_nq_s1[i][x][NUMA_W-1], den[x]);
				a_nq_s1[i+1][x] <= {a_nq_s1[i][x][NUMA_W-2:0],
					div_ge(a_rem_s1[i][x], a_nq_s1[i][x][NUMA_W-1], den[x])};
			end
		end
	end

	// Span times quotient, and span magnitude times remainder.
	always_ff @(posedge clk) begin
		for (int x = 0; x < 2; x++) begin
			for (int k = 0; k < 3; k++) begin
				p_s2[x][k] <= $signed(span[x][k]) * $signed({1'b0, a_nq_s1[DIVA_STEPS][x]});
				mr_s2[x][k] <= smag[x][k] * a_rem_s1[DIVA_STEPS][x][RES_W-2:0];
				neg_s2[x][k] <= span[x][k][LANE_W-1];
			end
		end
	end

	// The remainder product is divided again; its quotient stays below the span magnitude.
	always_ff @(posedge clk) begin
		for (int x = 0; x < 2; x++) begin
			for (int k = 0; k < 3; k++) begin
				c_rem_s3[0][x][k] <= mr_s2[x][k][MR_W-1:DIVC_STEPS];
				c_nq_s3[0][x][k] <= mr_s2[x][k][DIVC_STEPS-1:0];
				p_s3[0][x][k] <= p_s2[x][k];
				neg_s3[0][x][k] <= neg_s2[x][k];
				for (int i = 0; i < DIVC_STEPS; i++) begin
					c_rem_s3[i+1][x][k] <= div_rem(c_rem_s3[i][x][k],
						c_nq_s3[i][x][k][DIVC_STEPS-1], den[x]);
					c_nq_s3[i+1][x][k] <= {c_nq_s3[i][x][k][DIVC_STEPS-2:0],
						div_ge(c_rem_s3[i][x][k], c_nq_s3[i][x][k][DIVC_STEPS-1], den[x])};
					p_s3[i+1][x][k] <= p_s3[i][x][k];
					neg_s3[i+1][x][k] <= neg_s3[i][x][k];
				end
			end
		end
	end

	// Both parts share the sign of the span, so their sum truncates toward zero.
	always_comb begin
		for (int x = 0; x < 2; x++) begin
			for (int k = 0; k < 3; k++) begin
				t_next[x][k] = (P_W+1)'(p_s3[DIVC_STEPS][x][k])
					+ (neg_s3[DIVC_STEPS][x][k]
					? -$signed((P_W+1)'(c_nq_s3[DIVC_STEPS][x][k]))
					: $signed((P_W+1)'(c_nq_s3[DIVC_STEPS][x][k])));
			end
		end
	end

	always_ff @(posedge clk) begin
		t_s4 <= t_next;
	end

	// Corner minus camera, scaled to the direction format, plus both offsets.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_next[k] = $signed({{(D_W-LANE_W-17){cfg.corner[k][LANE_W-1]}}, cfg.corner[k], 16'b0})
				- $signed({{(D_W-LANE_W-17){cfg.cam[k][LANE_W-1]}}, cfg.cam[k], 16'b0})
				+ D_W'(t_s4[0][k]) + D_W'(t_s4[1][k]);
		end
	end

	always_ff @(posedge clk) begin
		d_s5 <= d_next;
	end

	assign out_valid = vld_s5;
	assign out_d[0] = d_s5[0];
	assign out_d[1] = d_s5[1];
	assign out_d[2] = d_s5[2];

endmodule

[rtl/pcr_norm.sv]
`timescale 1ns / 1ps
module pcr_norm import pcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [2:0][D_W-1:0] in_d,
	output logic out_valid,
	output logic [2:0][LANE_W-1:0] out_dir,
	output logic out_degenerate
);

	logic [4:0] vld_s;
	logic [M_W-1:0] mag_s1 [3];
	logic neg_s1 [3];
	logic [M_W-1:0] m_s2;
	logic [M_W-1:0] mag_s2 [3];
	logic neg_s2 [3];
	logic [4:0] shift;
	logic [A_W-1:0] a_s3 [3];
	logic neg_s3 [3];
	logic [SQ_W-1:0] sq_s4 [3];
	logic [A_W-1:0] a_s4 [3];
	logic neg_s4 [3];
	logic [SUM_W-1:0] sum_s5;
	logic [A_W-1:0] a_s5 [3];
	logic neg_s5 [3];

	logic [SQRT_STEPS:0] r_vld_s6;
	logic [SUM_W-1:0] rad_s6 [SQRT_STEPS+1];
	logic [SREM_W-1:0] rem_s6 [SQRT_STEPS+1];
	logic [ROOT_W-1:0] root_s6 [SQRT_STEPS+1];
	logic [A_W-1:0] a_s6 [SQRT_STEPS+1][3];
	logic neg_s6 [SQRT_STEPS+1][3];

	logic [DIVN_STEPS:0] q_vld_s7;
	logic [NN_W-1:0] num [3];
	logic [QN_W-1:0] qrem_s7 [DIVN_STEPS+1][3];
	logic [DIVN_STEPS-1:0] qnq_s7 [DIVN_STEPS+1][3];
	logic [QN_W-1:0] qden_s7 [DIVN_STEPS+1];
	logic zero_s7 [DIVN_STEPS+1];
	logic neg_s7 [DIVN_STEPS+1][3];

	logic vld_s8;
	logic [2:0][LANE_W-1:0] dir_s8;
	logic degen_s8;

	// One digit of the square root.
	function automatic logic sq_ge(input logic [SREM_W-1:0] rem, input logic [1:0] pair,
			input logic [ROOT_W-1:0] root);
		return {rem, pair} >= {2'b00, root, 2'b01};
	endfunction

	function automatic logic [SREM_W-1:0] sq_rem(input logic [SREM_W-1:0] rem,
			input logic [1:0] pair, input logic [ROOT_W-1:0] root);
		logic [SREM_W+1:0] t;
		logic [SREM_W+1:0] trial;
		t = {rem, pair};
		trial = {2'b00, root, 2'b01};
		return (t >= trial) ? SREM_W'(t - trial) : SREM_W'(t);
	endfunction

	// One quotient bit of the final division by twice the length.
	function automatic logic dv_ge(input logic [QN_W-1:0] rem, input logic b,
			input logic [QN_W-1:0] d);
		return {rem, b} >= {1'b0, d};
	endfunction

	function automatic logic [QN_W-1:0] dv_rem(input logic [QN_W-1:0] rem, input logic b,
			input logic [QN_W-1:0] d);
		logic [QN_W:0] t;
		t = {rem, b};
		return (t >= {1'b0, d}) ? QN_W'(t - {1'b0, d}) : t[QN_W-1:0];
	endfunction

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			r_vld_s6 <= '0;
			q_vld_s7 <= '0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s <= {vld_s[3:0], in_valid};
			r_vld_s6 <= {r_vld_s6[SQRT_STEPS-1:0], vld_s[4]};
			q_vld_s7 <= {q_vld_s7[DIVN_STEPS-1:0], r_vld_s6[SQRT_STEPS]};
			vld_s8 <= q_vld_s7[DIVN_STEPS];
		end
	end

	// Magnitudes and their largest value.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			neg_s1[k] <= in_d[k][D_W-1];
			mag_s1[k] <= in_d[k][D_W-1] ? M_W'(-in_d[k]) : in_d[k][M_W-1:0];
		end
		m_s2 <= (mag_s1[0] > mag_s1[1])
			? ((mag_s1[0] > mag_s1[2]) ? mag_s1[0] : mag_s1[2])
			: ((mag_s1[1] > mag_s1[2]) ? mag_s1[1] : mag_s1[2]);
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	// Smallest right shift that brings the largest magnitude below the limit.
	always_comb begin
		shift = '0;
		for (int i = 0; i < M_W - A_W; i++) begin
			if (m_s2[A_W+i]) begin
				shift = 5'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			a_s3[k] <= A_W'(mag_s2[k] >> shift);
			sq_s4[k] <= a_s3[k] * a_s3[k];
		end
		neg_s3 <= neg_s2;
		a_s4 <= a_s3;
		neg_s4 <= neg_s3;
		sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
		a_s5 <= a_s4;
		neg_s5 <= neg_s4;
	end

	// Floor square root, two radicand bits per stage.
	always_ff @(posedge clk) begin
		rad_s6[0] <= sum_s5;
		rem_s6[0] <= '0;
		root_s6[0] <= '0;
		a_s6[0] <= a_s5;
		neg_s6[0] <= neg_s5;
		for (int i = 0; i < SQRT_STEPS; i++) begin
			rad_s6[i+1] <= rad_s6[i] << 2;
			rem_s6[i+1] <= sq_rem(rem_s6[i], rad_s6[i][SUM_W-1:SUM_W-2], root_s6[i]);
			root_s6[i+1] <= {root_s6[i][ROOT_W-2:0],
				sq_ge(rem_s6[i], rad_s6[i][SUM_W-1:SUM_W-2], root_s6[i])};
			a_s6[i+1] <= a_s6[i];
			neg_s6[i+1] <= neg_s6[i];
		end
	end

	// Rounded quotient of magnitude by length, by dividing a plus half by twice n.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = {1'b0, a_s6[SQRT_STEPS][k], DIVN_STEPS'(0)}
				+ NN_W'(root_s6[SQRT_STEPS]);
		end
	end

	always_ff @(posedge clk) begin
		qden_s7[0] <= {root_s6[SQRT_STEPS], 1'b0};
		zero_s7[0] <= (root_s6[SQRT_STEPS] == '0);
		for (int k = 0; k < 3; k++) begin
			qrem_s7[0][k] <= QN_W'(num[k][NN_W-1:DIVN_STEPS]);
			qnq_s7[0][k] <= num[k][DIVN_STEPS-1:0];
			neg_s7[0][k] <= neg_s6[SQRT_STEPS][k];
		end
		for (int i = 0; i < DIVN_STEPS; i++) begin
			qden_s7[i+1] <= qden_s7[i];
			zero_s7[i+1] <= zero_s7[i];
			for (int k = 0; k < 3; k++) begin
				qrem_s7[i+1][k] <= dv_rem(qrem_s7[i][k], qnq_s7[i][k][DIVN_STEPS-1], qden_s7[i]);
				qnq_s7[i+1][k] <= {qnq_s7[i][k][DIVN_STEPS-2:0],
					dv_ge(qrem_s7[i][k], qnq_s7[i][k][DIVN_STEPS-1], qden_s7[i])};
				neg_s7[i+1][k] <= neg_s7[i][k];
			end
		end
	end

	// Signed result; a zero length gives the zero vector.
	always_ff @(posedge clk) begin
		degen_s8 <= zero_s7[DIVN_STEPS];
		for (int k = 0; k < 3; k++) begin
			if (zero_s7[DIVN_STEPS]) begin
				dir_s8[k] <= '0;
			end else if (neg_s7[DIVN_STEPS][k]) begin
				dir_s8[k] <= LANE_W'(-{1'b0, qnq_s7[DIVN_STEPS][k]});
			end else begin
				dir_s8[k] <= {1'b0, qnq_s7[DIVN_STEPS][k]};
			end
		end
	end

	assign out_valid = vld_s8;
	assign out_dir = dir_s8;
	assign out_degenerate = degen_s8;

endmodule

[rtl/pinhole_camera_ray_generator.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// command   in         start, busy            pixel_x, pixel_y, jitter_x, jitter_y
// config    in         cfg_valid, cfg_ready   cfg_index, cfg_data
// result    out        done (one cycle)       origin_x/y/z, dir_x/y/z, degenerate
//
// One word is accepted per cycle, and each accepted word gives one result.
// The latency is set by the bit-per-stage pipelines: the coordinate divider (28 stages),
// the offset divider (15), the square root (31) and the normalizing divider (15).
// Reset clears the pipeline and loads the default camera; no clearing pass is needed.
// The result side cannot stall and the queue drains a word whenever one waits, so it
// never fills and busy stays low.
module pinhole_camera_ray_generator import pcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [PIX_W-1:0] pixel_x,
	input logic [PIX_W-1:0] pixel_y,
	input logic [JITTER_BITS-1:0] jitter_x,
	input logic [JITTER_BITS-1:0] jitter_y,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	output logic done,
	output logic signed [LANE_W-1:0] origin_x,
	output logic signed [LANE_W-1:0] origin_y,
	output logic signed [LANE_W-1:0] origin_z,
	output logic signed [LANE_W-1:0] dir_x,
	output logic signed [LANE_W-1:0] dir_y,
	output logic signed [LANE_W-1:0] dir_z,
	output logic degenerate
);

	pcr_cfg_t cfg;
	logic push;
	pcr_item_t push_item;
	logic pop_valid;
	pcr_item_t pop_item;
	logic proj_valid;
	logic [2:0][D_W-1:0] proj_d;
	logic [2:0][LANE_W-1:0] dir;

	pcr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.jitter_x(jitter_x),
		.jitter_y(jitter_y),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg_ready(cfg_ready),
		.push(push),
		.push_item(push_item),
		.cfg(cfg)
	);

	pcr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(busy),
		.pop_valid(pop_valid),
		.pop_item(pop_item)
	);

	pcr_proj u_proj (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pop_valid),
		.in_item(pop_item),
		.cfg(cfg),
		.out_valid(proj_valid),
		.out_d(proj_d)
	);

	pcr_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(proj_valid),
		.in_d(proj_d),
		.out_valid(done),
		.out_dir(dir),
		.out_degenerate(degenerate)
	);

	// The ray starts at the camera; the user must keep it stable while words are in flight (not enforced).
	assign origin_x = cfg.cam[0];
	assign origin_y = cfg.cam[1];
	assign origin_z = cfg.cam[2];
	assign dir_x = dir[0];
	assign dir_y = dir[1];
	assign dir_z = dir[2];

`ifndef SYNTHESIS
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##RESULT_LATENCY done)
		else $error("accepted word gave no result at the expected cycle");
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, RESULT_LATENCY))
		else $error("result strobe without a matching accepted word");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0))
		else $error("degenerate ray carries a nonzero direction");
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (dir_x <= 16'sd16384 && dir_x >= -16'sd16384
			&& dir_y <= 16'sd16384 && dir_y >= -16'sd16384
			&& dir_z <= 16'sd16384 && dir_z >= -16'sd16384))
		else $error("direction component exceeds unit length");
`endif

endmodule
